>>> sv/srr_pkg.sv
// Package for the selective-repeat receiver: command type, back-end state
// codes and the fixed ACK constants. No dependencies.
package srr_pkg;

  localparam int unsigned SEQ_W = 7;
  localparam int unsigned CK_W  = 16;
  localparam int unsigned PL_W  = 64;

  localparam logic [PL_W-1:0] ACK_BYTES = 64'h0000_0000_004B_4341;
  localparam logic [CK_W-1:0] ACK_SUM   = 16'd207;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
    logic [PL_W-1:0]  payload;
  } srr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DELIVER,
    ST_ACK
  } srr_state_e;

endpackage

>>> sv/selective_repeat_receiver_top.sv
// Selective-repeat receiver top level. The first result of a packet passes the queue write,
// the back-end pop and the output register, in that order. An in-order packet takes a pop,
// its deliveries, a step to find the empty head and an ACK; other ACKed packets a pop and
// an ACK; far-out packets are popped with no ACK. The back end pops a packet only when done
// with the last. Corrupt packets are dropped at the front. Output stalls hold the back end.
// Reset clears the window base, present flags, queue and output valid. Depends on srr_pkg.
module selective_repeat_receiver_top import srr_pkg::*; #(
  parameter int unsigned WINDOW_SIZE   = 8,
  parameter int unsigned SEQ_LIMIT     = 128,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic [SEQ_W-1:0] ack_num_i,
  input  logic [CK_W-1:0]  pkt_checksum_i,
  input  logic [PL_W-1:0]  payload_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             result_kind_o,
  output logic [SEQ_W-1:0] out_seq_o,
  output logic [SEQ_W-1:0] out_ack_o,
  output logic [CK_W-1:0]  out_checksum_o,
  output logic [PL_W-1:0]  out_payload_o,
  output logic             out_last_o
);

  logic     q_full, q_push, q_pop, q_valid;
  srr_cmd_t q_in, q_out;

  srr_front #(
    .SEQ_LIMIT    (SEQ_LIMIT),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .seq_num_i     (seq_num_i),
    .ack_num_i     (ack_num_i),
    .pkt_checksum_i(pkt_checksum_i),
    .payload_i     (payload_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  srr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_out)
  );

  srr_back #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .SEQ_LIMIT  (SEQ_LIMIT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_seq_o     (out_seq_o),
    .out_ack_o     (out_ack_o),
    .out_checksum_o(out_checksum_o),
    .out_payload_o (out_payload_o),
    .out_last_o    (out_last_o)
  );

endmodule

>>> sv/srr_front.sv
// Front end: checksum check, payload narrowing and drop of bad packets.
// Depends on srr_pkg.
module srr_front import srr_pkg::*; #(
  parameter int unsigned SEQ_LIMIT     = 128,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SEQ_W-1:0] seq_num_i,
  input  logic [SEQ_W-1:0] ack_num_i,
  input  logic [CK_W-1:0]  pkt_checksum_i,
  input  logic [PL_W-1:0]  payload_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output srr_cmd_t         q_data_o
);

  logic [11:0]     sum;
  logic [PL_W-1:0] pl_masked;
  logic            ck_ok;
  logic            seq_ok;

  always_comb begin
    sum       = 12'(seq_num_i) + 12'(ack_num_i);
    pl_masked = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < int'(PAYLOAD_BYTES)) begin
        pl_masked[8*b +: 8] = payload_i[8*b +: 8];
        sum                 = sum + 12'(payload_i[8*b +: 8]);
      end
    end
  end

  assign ck_ok      = ({4'b0, sum} == pkt_checksum_i);
  assign seq_ok     = ({2'b0, seq_num_i} < 9'(SEQ_LIMIT));
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && ck_ok && seq_ok;

  always_comb begin
    q_data_o.seq     = seq_num_i;
    q_data_o.ack     = ack_num_i;
    q_data_o.payload = pl_masked;
  end

endmodule

>>> sv/srr_queue.sv
// Two-entry command queue between front and back end.
// Depends on srr_pkg.
module srr_queue import srr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  srr_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output srr_cmd_t data_o
);

  srr_cmd_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> sv/srr_back.sv
// Back end: receive window, payload ring, in-order release and ACK output
// register. Depends on srr_pkg.
module srr_back import srr_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 8,
  parameter int unsigned SEQ_LIMIT   = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  srr_cmd_t         q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             result_kind_o,
  output logic [SEQ_W-1:0] out_seq_o,
  output logic [SEQ_W-1:0] out_ack_o,
  output logic [CK_W-1:0]  out_checksum_o,
  output logic [PL_W-1:0]  out_payload_o,
  output logic             out_last_o
);

  localparam int unsigned BASE_W = $clog2(SEQ_LIMIT);
  localparam int unsigned HEAD_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  srr_state_e        state_q, state_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [HEAD_W-1:0] head_q, head_d;
  logic [WINDOW_SIZE-1:0] present_q;
  logic [PL_W-1:0]   slot_q [WINDOW_SIZE];
  logic [SEQ_W-1:0]  seq_q, ack_q;

  logic [BASE_W:0]   diff;
  logic [BASE_W-1:0] off;
  logic              in_win, near;
  logic [HEAD_W:0]   slot_sum;
  logic [HEAD_W-1:0] slot;
  logic              head_present;

  logic              pop, wr_en, deliver_en, ack_en, can_emit;

  logic              out_valid_q;
  logic              kind_q, last_q;
  logic [SEQ_W-1:0]  oseq_q, oack_q;
  logic [CK_W-1:0]   ock_q;
  logic [PL_W-1:0]   opl_q;

  always_comb begin
    diff = (BASE_W+1)'(q_data_i.seq) - {1'b0, base_q};
    if (diff[BASE_W]) begin
      diff = diff + (BASE_W+1)'(SEQ_LIMIT);
    end
    off      = diff[BASE_W-1:0];
    in_win   = (10'(off) < 10'(WINDOW_SIZE));
    near     = ((10'(off) + 10'(WINDOW_SIZE)) >= 10'(SEQ_LIMIT));
    slot_sum = (HEAD_W+1)'(head_q) + (HEAD_W+1)'(off);
    if (slot_sum >= (HEAD_W+1)'(WINDOW_SIZE)) begin
      slot_sum = slot_sum - (HEAD_W+1)'(WINDOW_SIZE);
    end
    slot = slot_sum[HEAD_W-1:0];
  end

  assign head_present = present_q[head_q];
  assign can_emit     = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (in_win && (off == '0)) begin
            state_d = ST_DELIVER;
          end else if (in_win || near) begin
            state_d = ST_ACK;
          end
        end
      end
      ST_DELIVER: begin
        if (!head_present) begin
          state_d = ST_ACK;
        end
      end
      ST_ACK: begin
        if (can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop        = 1'b0;
    wr_en      = 1'b0;
    deliver_en = 1'b0;
    ack_en     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop   = q_valid_i;
        wr_en = q_valid_i && in_win;
      end
      ST_DELIVER: deliver_en = head_present && can_emit;
      ST_ACK:     ack_en     = can_emit;
      default: ;
    endcase
  end

  assign q_pop_o = pop;

  always_comb begin
    base_d = base_q;
    head_d = head_q;
    if (deliver_en) begin
      base_d = (base_q == BASE_W'(SEQ_LIMIT - 1)) ? '0 : base_q + 1'b1;
      head_d = (head_q == HEAD_W'(WINDOW_SIZE - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[slot] <= q_data_i.payload;
    end
    if (pop) begin
      seq_q <= q_data_i.seq;
      ack_q <= q_data_i.ack;
    end
    if (deliver_en) begin
      kind_q <= KIND_DELIVER;
      oseq_q <= SEQ_W'(base_q);
      oack_q <= '0;
      ock_q  <= '0;
      opl_q  <= slot_q[head_q];
      last_q <= 1'b0;
    end else if (ack_en) begin
      kind_q <= KIND_ACK;
      oseq_q <= seq_q;
      oack_q <= ack_q;
      ock_q  <= CK_W'(seq_q) + CK_W'(ack_q) + ACK_SUM;
      opl_q  <= ACK_BYTES;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      head_q      <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      head_q  <= head_d;
      if (wr_en) begin
        present_q[slot] <= 1'b1;
      end
      if (deliver_en) begin
        present_q[head_q] <= 1'b0;
      end
      if (deliver_en || ack_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign out_seq_o      = oseq_q;
  assign out_ack_o      = oack_q;
  assign out_checksum_o = ock_q;
  assign out_payload_o  = opl_q;
  assign out_last_o     = last_q;

endmodule
